// ===== src/allm_pkg.sv =====
// Shared constants for the array linked list manager: operation and status codes
// and the default sizes of the slot arrays. It depends on nothing else.
`default_nettype none

package allm_pkg;

  localparam int LIST_SLOTS_DEF  = 63;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_NEXT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

endpackage

`default_nettype wire

// ===== src/allm_ifs.sv =====
// Valid/ready channels of the list manager: the request channel and the response channel.
// Widths of the opcode and status fields come from allm_pkg.
`default_nettype none

interface allm_req_if #(
  parameter int SLOT_W  = 6,
  parameter int VALUE_W = allm_pkg::VALUE_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [allm_pkg::OP_W-1:0]   op;
  logic [SLOT_W-1:0]           slot_index;
  logic signed [VALUE_W-1:0]   value;

  modport source (output valid, output op, output slot_index, output value, input ready);
  modport sink   (input valid, input op, input slot_index, input value, output ready);
endinterface

interface allm_rsp_if #(
  parameter int SLOT_W = 6
);
  logic                          valid;
  logic                          ready;
  logic [allm_pkg::STATUS_W-1:0] status;
  logic [SLOT_W-1:0]             slot_out;
  logic [SLOT_W-1:0]             head;
  logic [SLOT_W-1:0]             tail;

  modport source (output valid, output status, output slot_out, output head, output tail,
                  input ready);
  modport sink   (input valid, input status, input slot_out, input head, input tail,
                  output ready);
endinterface

`default_nettype wire

// ===== src/array_linked_list_manager_unit.sv =====
// Top level of the array linked list manager: link memories, sequencer and result register.
// Depends on allm_pkg and the channel interfaces in allm_ifs.sv.
`default_nettype none

// A doubly linked list of LIST_SLOTS elements kept in three synchronous memories (next
// links, prev links with an occupied flag, and values), with slot 0 as the sentinel whose
// links live in the head and tail registers. Free slots are chained through next from
// free_head. After reset the block runs a clearing pass over every slot that builds the
// free chain; it takes no request word during that pass. An insert or a delete then passes
// through S_READ, S_EXEC, S_WR2 and S_DONE (a read state, then the write states S_EXEC and
// S_WR2, as each link memory has one write port); a read-next or a rejected request skips
// S_WR2. The next request is taken in the cycle its predecessor's response is loaded. The
// response register lets a new request in while a response still waits to be taken.
module array_linked_list_manager_unit #(
  parameter int LIST_SLOTS  = allm_pkg::LIST_SLOTS_DEF,
  parameter int VALUE_WIDTH = allm_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  allm_req_if.sink    req,
  allm_rsp_if.source  rsp
);

  localparam int SW = $clog2(LIST_SLOTS + 1);
  localparam logic [SW-1:0] LAST = SW'(LIST_SLOTS);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_WR2   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  // Link memories; prv_mem holds {occupied, prev}.
  logic [SW-1:0]          nxt_mem [0:LIST_SLOTS];
  logic [SW:0]            prv_mem [0:LIST_SLOTS];
  logic [VALUE_WIDTH-1:0] val_mem [0:LIST_SLOTS];

  logic [SW-1:0] nxt_rd_a, nxt_rd_b;
  logic [SW:0]   prv_rd;

  logic          nxt_we, prv_we, val_we;
  logic [SW-1:0] nxt_wa, nxt_wd, prv_wa;
  logic [SW:0]   prv_wd;

  logic [SW-1:0] clr_cnt;
  logic [SW-1:0] head, tail, free_head;

  logic [allm_pkg::OP_W-1:0] req_op;
  logic [SW-1:0]             req_slot;
  logic [VALUE_WIDTH-1:0]    req_value;

  logic [SW-1:0] pos_q, aft_q, new_q;
  logic          del_q;
  logic [allm_pkg::STATUS_W-1:0] res_status;
  logic [SW-1:0]                 res_slot;

  logic out_valid, out_free, in_ready, in_take;

  logic          in_range, pos_occ, do_ins, do_del;
  logic [SW-1:0] pos, pos_nxt, del_prev;
  logic [allm_pkg::STATUS_W-1:0] status_c;
  logic [SW-1:0]                 slot_c;

  assign out_free  = !out_valid || rsp.ready;
  assign in_ready  = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign in_take   = in_ready && req.valid;
  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  // Target position of the request; out-of-range slots read entry 0 and are rejected.
  assign in_range = (req_slot <= LAST);
  always_comb begin
    case (req_op)
      allm_pkg::OP_INS_FRONT: pos = '0;
      allm_pkg::OP_INS_BACK:  pos = tail;
      default:                pos = in_range ? req_slot : '0;
    endcase
  end

  // Sentinel links come from the head and tail registers.
  assign pos_occ  = (pos == '0) || prv_rd[SW];
  assign pos_nxt  = (pos == '0) ? head : nxt_rd_a;
  assign del_prev = prv_rd[SW-1:0];

  always_comb begin
    status_c = allm_pkg::ST_BAD;
    slot_c   = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    case (req_op)
      allm_pkg::OP_INS_AFTER, allm_pkg::OP_INS_FRONT, allm_pkg::OP_INS_BACK: begin
        if ((req_op == allm_pkg::OP_INS_AFTER) && !(in_range && pos_occ)) begin
          status_c = allm_pkg::ST_BAD;
        end else if (free_head == '0) begin
          status_c = allm_pkg::ST_FULL;
        end else begin
          status_c = allm_pkg::ST_OK;
          slot_c   = free_head;
          do_ins   = 1'b1;
        end
      end
      allm_pkg::OP_DELETE: begin
        if ((req_slot != '0) && in_range && prv_rd[SW]) begin
          status_c = allm_pkg::ST_OK;
          slot_c   = req_slot;
          do_del   = 1'b1;
        end
      end
      allm_pkg::OP_READ_NEXT: begin
        if (in_range && pos_occ) begin
          status_c = allm_pkg::ST_OK;
          slot_c   = pos_nxt;
        end
      end
      default: begin
        status_c = allm_pkg::ST_BAD;
      end
    endcase
  end

  // Memory write ports.
  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = '0;
    nxt_wd = '0;
    prv_we = 1'b0;
    prv_wa = '0;
    prv_wd = '0;
    val_we = 1'b0;
    case (state)
      S_CLEAR: begin
        nxt_we = 1'b1;
        nxt_wa = clr_cnt;
        nxt_wd = ((clr_cnt == LAST) || (clr_cnt == '0)) ? '0 : clr_cnt + SW'(1);
        prv_we = 1'b1;
        prv_wa = clr_cnt;
      end
      S_EXEC: begin
        if (do_ins) begin
          // Fill the new slot from the free list.
          nxt_we = 1'b1;
          nxt_wa = free_head;
          nxt_wd = pos_nxt;
          prv_we = 1'b1;
          prv_wa = free_head;
          prv_wd = {1'b1, pos};
          val_we = 1'b1;
        end else if (do_del) begin
          // Unlink the slot from its neighbors.
          nxt_we = 1'b1;
          nxt_wa = del_prev;
          nxt_wd = nxt_rd_a;
          prv_we = 1'b1;
          prv_wa = nxt_rd_a;
          prv_wd = {1'b1, del_prev};
        end
      end
      S_WR2: begin
        nxt_we = 1'b1;
        nxt_wa = pos_q;
        prv_we = 1'b1;
        if (del_q) begin
          nxt_wd = free_head;
          prv_wa = pos_q;
          prv_wd = '0;
        end else begin
          nxt_wd = new_q;
          prv_wa = aft_q;
          prv_wd = {1'b1, new_q};
        end
      end
      default: begin
        nxt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (val_we) val_mem[free_head] <= req_value;
    nxt_rd_a <= nxt_mem[pos];
    nxt_rd_b <= nxt_mem[free_head];
    prv_rd   <= prv_mem[pos];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == LAST) state_next = S_IDLE;
      S_IDLE:  if (in_take) state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = (do_ins || do_del) ? S_WR2 : S_DONE;
      S_WR2:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = in_take ? S_READ : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      head      <= '0;
      tail      <= '0;
      free_head <= SW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + SW'(1);
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      if (state == S_EXEC) begin
        if (do_ins) begin
          free_head <= nxt_rd_b;
        end else if (do_del) begin
          if (del_prev == '0) head <= nxt_rd_a;
          if (nxt_rd_a == '0) tail <= del_prev;
        end
      end
      if (state == S_WR2) begin
        if (del_q) begin
          free_head <= pos_q;
        end else begin
          if (pos_q == '0) head <= new_q;
          if (aft_q == '0) tail <= new_q;
        end
      end
    end
  end

  // Request, work and response payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_op    <= req.op;
      req_slot  <= req.slot_index;
      req_value <= req.value;
    end
    if (state == S_EXEC) begin
      res_status <= status_c;
      res_slot   <= slot_c;
      del_q      <= do_del;
      pos_q      <= do_del ? req_slot : pos;
      aft_q      <= pos_nxt;
      new_q      <= free_head;
    end
    if ((state == S_DONE) && out_free) begin
      rsp.status   <= res_status;
      rsp.slot_out <= res_slot;
      rsp.head     <= head;
      rsp.tail     <= tail;
    end
  end

endmodule

`default_nettype wire
